// File: hdl/lca_pkg.sv
package lca_pkg;

  // default grid size
  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_GRID_ROWS = 64;

  // field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // reset value of the area limits
  localparam logic [CFG_W-1:0] AREA_MAX_RST = 6'd63;

  // neighbour counts of the B3/S23 rule
  localparam logic [3:0] NB_SURVIVE = 4'd2;
  localparam logic [3:0] NB_BIRTH   = 4'd3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_LAST_COL = 1'b0;
  localparam logic REG_LAST_ROW = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic cell_value;
    logic out_of_area;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_STEP,
    ST_RESP
  } state_t;

endpackage

// File: hdl/life_cellular_automaton.sv
// channel | signals                               | direction
// --------+---------------------------------------+----------
// in      | in_valid, in_ready, in_data           | to block
// out     | out_valid, out_ready, out_data        | from block
// cfg     | psel, penable, pwrite, paddr, pwdata, | both
//         | prdata, pready                        |
//
// After reset the grid memory is swept to all dead, one row a cycle, with in_ready
// low. Toggle and read items in the area go through idle, access and response
// (row read, modify and write back, result); other non-step items skip access. A
// step scans the active rows, one row read and one row written each cycle through
// a three-row window. One item is worked at a time; a waiting result sits in the
// output register while the next item is accepted, and a new result waits for it.
module life_cellular_automaton #(
  parameter int GRID_COLS = lca_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lca_pkg::DEF_GRID_ROWS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lca_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lca_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lca_pkg::PADDR_W-1:0]  paddr,
  input  logic [lca_pkg::PDATA_W-1:0]  pwdata,
  output logic [lca_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CW  = $clog2(GRID_COLS);
  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CXW = (CW > lca_pkg::COORD_W) ? CW : lca_pkg::COORD_W;
  localparam int RXW = (RW > lca_pkg::COORD_W) ? RW : lca_pkg::COORD_W;

  logic [lca_pkg::CFG_W-1:0] last_col;
  logic [lca_pkg::CFG_W-1:0] last_row;

  lca_pkg::state_t state, state_next;

  logic [RW:0]            scan;
  logic [GRID_COLS-1:0]   up_row;
  logic [GRID_COLS-1:0]   mid_row;
  logic [GRID_COLS-1:0]   dn_row;
  logic [GRID_COLS-1:0]   new_row;
  logic                   op_toggle;
  logic [CW-1:0]          col_q;
  logic [RW-1:0]          row_q;
  logic                   pend_value;
  logic                   pend_out;

  logic                   mem_we;
  logic [RW-1:0]          mem_waddr;
  logic [GRID_COLS-1:0]   mem_wdata;
  logic [RW-1:0]          mem_raddr;
  logic [GRID_COLS-1:0]   mem_rdata;

  logic [CXW-1:0]         cmax_x;
  logic [RXW-1:0]         rmax_x;
  logic [CXW-1:0]         col_x;
  logic [RXW-1:0]         row_x;
  logic [CW-1:0]          cmax;
  logic [RW:0]            rmax_s;
  logic                   in_acc;
  logic                   in_outside;
  logic                   is_cell_op;
  logic                   out_free;
  logic                   step_done;
  logic                   clear_done;

  lca_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .last_col (last_col),
    .last_row (last_row)
  );

  lca_grid_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lca_row_update #(
    .COLS (GRID_COLS)
  ) u_rule (
    .up_row  (up_row),
    .mid_row (mid_row),
    .dn_row  (dn_row),
    .cmax    (cmax),
    .new_row (new_row)
  );

  // active area clipped to the grid
  assign cmax_x = (CXW'(last_col) < CXW'(GRID_COLS - 1)) ? CXW'(last_col)
                                                         : CXW'(GRID_COLS - 1);
  assign rmax_x = (RXW'(last_row) < RXW'(GRID_ROWS - 1)) ? RXW'(last_row)
                                                         : RXW'(GRID_ROWS - 1);
  assign cmax   = cmax_x[CW-1:0];
  assign rmax_s = (RW+1)'(rmax_x[RW-1:0]);

  // incoming coordinates
  assign col_x      = CXW'(in_data.cell_col);
  assign row_x      = RXW'(in_data.cell_row);
  assign in_outside = (col_x > cmax_x) || (row_x > rmax_x);
  assign is_cell_op = (in_data.op == lca_pkg::OP_TOGGLE) ||
                      (in_data.op == lca_pkg::OP_READ);

  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign step_done  = (scan == rmax_s + (RW+1)'(1));
  assign clear_done = (scan == (RW+1)'(GRID_ROWS - 1));

  // row below is dead past the last active row
  assign dn_row = (scan <= rmax_s) ? mem_rdata : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lca_pkg::ST_CLEAR: begin
        if (clear_done) begin
          state_next = lca_pkg::ST_IDLE;
        end
      end
      lca_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == lca_pkg::OP_STEP) begin
            state_next = lca_pkg::ST_STEP;
          end else if (is_cell_op && !in_outside) begin
            state_next = lca_pkg::ST_ACCESS;
          end else begin
            state_next = lca_pkg::ST_RESP;
          end
        end
      end
      lca_pkg::ST_ACCESS: state_next = lca_pkg::ST_RESP;
      lca_pkg::ST_STEP: begin
        if (step_done) begin
          state_next = lca_pkg::ST_RESP;
        end
      end
      lca_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = lca_pkg::ST_IDLE;
        end
      end
      default: state_next = lca_pkg::ST_IDLE;
    endcase
  end

  // memory port control and handshake
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      lca_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan[RW-1:0];
      end
      lca_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_data.op != lca_pkg::OP_STEP) begin
          mem_raddr = row_x[RW-1:0];
        end
      end
      lca_pkg::ST_ACCESS: begin
        mem_we    = op_toggle;
        mem_waddr = row_q;
        mem_wdata = mem_rdata ^ (GRID_COLS'(1) << col_q);
      end
      lca_pkg::ST_STEP: begin
        mem_raddr = RW'(scan + (RW+1)'(1));
        if (scan != '0) begin
          mem_we    = 1'b1;
          mem_waddr = RW'(scan - (RW+1)'(1));
          mem_wdata = new_row;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lca_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sweep counter and row scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else begin
      case (state)
        lca_pkg::ST_CLEAR: scan <= clear_done ? '0 : scan + (RW+1)'(1);
        lca_pkg::ST_IDLE:  scan <= '0;
        lca_pkg::ST_STEP:  scan <= scan + (RW+1)'(1);
        default:           scan <= scan;
      endcase
    end
  end

  // item capture, row window and pending result
  always_ff @(posedge clk) begin
    if (state == lca_pkg::ST_IDLE && in_acc) begin
      op_toggle  <= (in_data.op == lca_pkg::OP_TOGGLE);
      col_q      <= col_x[CW-1:0];
      row_q      <= row_x[RW-1:0];
      pend_value <= 1'b0;
      pend_out   <= is_cell_op && in_outside;
    end
    if (state == lca_pkg::ST_ACCESS) begin
      pend_value <= mem_rdata[col_q] ^ op_toggle;
    end
    if (state == lca_pkg::ST_STEP) begin
      up_row  <= (scan == '0) ? '0 : mid_row;
      mid_row <= mem_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == lca_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lca_pkg::ST_RESP && out_free) begin
      out_data.cell_value  <= pend_value;
      out_data.out_of_area <= pend_out;
    end
  end

endmodule

// File: hdl/lca_grid_mem.sv
module lca_grid_mem #(
  parameter int ROWS = lca_pkg::DEF_GRID_ROWS,
  parameter int COLS = lca_pkg::DEF_GRID_COLS,
  localparam int RW = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [RW-1:0]   waddr,
  input  logic [COLS-1:0] wdata,
  input  logic [RW-1:0]   raddr,
  output logic [COLS-1:0] rdata
);

  // one row of cells per entry
  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lca_row_update.sv
module lca_row_update #(
  parameter int COLS = lca_pkg::DEF_GRID_COLS,
  localparam int CW = $clog2(COLS)
) (
  input  logic [COLS-1:0] up_row,
  input  logic [COLS-1:0] mid_row,
  input  logic [COLS-1:0] dn_row,
  input  logic [CW-1:0]   cmax,
  output logic [COLS-1:0] new_row
);

  logic [COLS-1:0] col_mask;
  logic [COLS+1:0] u_pad;
  logic [COLS+1:0] m_pad;
  logic [COLS+1:0] d_pad;
  logic [COLS-1:0] live;

  // columns inside the active area
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_mask[c] = (CW'(c) <= cmax);
    end
  end

  // cells outside the area and outside the grid count as dead
  assign u_pad = {1'b0, up_row & col_mask, 1'b0};
  assign m_pad = {1'b0, mid_row & col_mask, 1'b0};
  assign d_pad = {1'b0, dn_row & col_mask, 1'b0};

  // per-column neighbour count and rule
  always_comb begin
    logic [3:0] cnt;
    for (int c = 0; c < COLS; c++) begin
      cnt = 4'(u_pad[c]) + 4'(u_pad[c+1]) + 4'(u_pad[c+2])
          + 4'(m_pad[c]) + 4'(m_pad[c+2])
          + 4'(d_pad[c]) + 4'(d_pad[c+1]) + 4'(d_pad[c+2]);
      live[c] = (cnt == lca_pkg::NB_BIRTH) ||
                ((cnt == lca_pkg::NB_SURVIVE) && m_pad[c+1]);
    end
  end

  // cells right of the area keep their value
  assign new_row = (live & col_mask) | (mid_row & ~col_mask);

endmodule

// File: hdl/lca_cfg_regs.sv
module lca_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lca_pkg::PADDR_W-1:0]  paddr,
  input  logic [lca_pkg::PDATA_W-1:0]  pwdata,
  output logic [lca_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [lca_pkg::CFG_W-1:0]    last_col,
  output logic [lca_pkg::CFG_W-1:0]    last_row
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // area limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= lca_pkg::AREA_MAX_RST;
      last_row <= lca_pkg::AREA_MAX_RST;
    end else if (wr_en) begin
      if (paddr[2] == lca_pkg::REG_LAST_COL) begin
        last_col <= pwdata[lca_pkg::CFG_W-1:0];
      end else begin
        last_row <= pwdata[lca_pkg::CFG_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == lca_pkg::REG_LAST_ROW) begin
      prdata = lca_pkg::PDATA_W'(last_row);
    end else begin
      prdata = lca_pkg::PDATA_W'(last_col);
    end
  end

endmodule

// File: dv/tb.sv
module tb;

  localparam logic [lca_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  lca_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lca_pkg::out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lca_pkg::PADDR_W-1:0] paddr = '0;
  logic [lca_pkg::PDATA_W-1:0] pwdata = '0;
  logic [lca_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // shadow of the block: grid indexed [row][col] and area limits
  bit [63:0] shadow_grid [64];
  logic [lca_pkg::CFG_W-1:0] area_cols = lca_pkg::AREA_MAX_RST;
  logic [lca_pkg::CFG_W-1:0] area_rows = lca_pkg::AREA_MAX_RST;

  lca_pkg::out_item_t pending_answers [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  logic calm = 1'b0;

  life_cellular_automaton uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // live cells around one cell, anything outside the area counts as dead
  function automatic int live_around(int r, int c);
    int n;
    int rr;
    int cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
            rr <= int'(area_rows) && cc <= int'(area_cols))
          n += shadow_grid[rr][cc];
      end
    end
    return n;
  endfunction

  // one b3/s23 generation over the active area, built apart from the old grid
  function automatic void next_generation();
    bit [63:0] fresh [64];
    int n;
    fresh = shadow_grid;
    for (int r = 0; r <= int'(area_rows); r++) begin
      for (int c = 0; c <= int'(area_cols); c++) begin
        n = live_around(r, c);
        fresh[r][c] = (n == 3) || (n == 2 && shadow_grid[r][c]);
      end
    end
    shadow_grid = fresh;
  endfunction

  // expected answer to one accepted item, updating the shadow grid
  function automatic lca_pkg::out_item_t cell_answer(lca_pkg::in_item_t it);
    lca_pkg::out_item_t a;
    a = '0;
    case (it.op)
      lca_pkg::OP_STEP: begin
        next_generation();
      end
      lca_pkg::OP_TOGGLE, lca_pkg::OP_READ: begin
        if (it.cell_col > area_cols || it.cell_row > area_rows) begin
          a.out_of_area = 1'b1;
        end else begin
          if (it.op == lca_pkg::OP_TOGGLE)
            shadow_grid[it.cell_row][it.cell_col] ^= 1'b1;
          a.cell_value = shadow_grid[it.cell_row][it.cell_col];
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // send one item, leaving valid high unless a gap follows
  task automatic send_item(logic [lca_pkg::OP_W-1:0] op,
                           logic [lca_pkg::COORD_W-1:0] col,
                           logic [lca_pkg::COORD_W-1:0] row);
    lca_pkg::in_item_t it;
    it.op = op;
    it.cell_col = col;
    it.cell_row = row;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(cell_answer(it));
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop sending and let every result come back
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write one area register, then read it back
  task automatic write_area_reg(logic idx, logic [lca_pkg::CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {$urandom_range(0, 1) ? 26'($urandom) : 26'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lca_pkg::REG_LAST_COL)
      area_cols = value;
    else
      area_rows = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[lca_pkg::CFG_W-1:0] !== value)
      report_mismatch($sformatf("register %0d reads %0d, wrote %0d",
                                idx, prdata[lca_pkg::CFG_W-1:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_area(int cols, int rows);
    wait_until_quiet();
    write_area_reg(lca_pkg::REG_LAST_COL, cols[lca_pkg::CFG_W-1:0]);
    write_area_reg(lca_pkg::REG_LAST_ROW, rows[lca_pkg::CFG_W-1:0]);
    @(posedge clk);
  endtask

  // corners of the full grid right after reset, isolated cells die on a step
  task automatic test_reset_corners();
    send_item(lca_pkg::OP_READ, 6'd0, 6'd0);
    send_item(lca_pkg::OP_TOGGLE, 6'd0, 6'd0);
    send_item(lca_pkg::OP_TOGGLE, 6'd63, 6'd63);
    send_item(lca_pkg::OP_TOGGLE, 6'd63, 6'd0);
    send_item(lca_pkg::OP_TOGGLE, 6'd0, 6'd63);
    send_item(lca_pkg::OP_READ, 6'd63, 6'd63);
    send_item(lca_pkg::OP_STEP, 6'd0, 6'd0);
    send_item(lca_pkg::OP_READ, 6'd0, 6'd0);
  endtask

  // still block in a corner and a blinker on the bottom edge
  task automatic test_edge_patterns();
    send_item(lca_pkg::OP_TOGGLE, 6'd0, 6'd0);
    send_item(lca_pkg::OP_TOGGLE, 6'd1, 6'd0);
    send_item(lca_pkg::OP_TOGGLE, 6'd0, 6'd1);
    send_item(lca_pkg::OP_TOGGLE, 6'd1, 6'd1);
    send_item(lca_pkg::OP_TOGGLE, 6'd30, 6'd63);
    send_item(lca_pkg::OP_TOGGLE, 6'd31, 6'd63);
    send_item(lca_pkg::OP_TOGGLE, 6'd32, 6'd63);
    send_item(lca_pkg::OP_STEP, 6'd63, 6'd63);
    send_item(lca_pkg::OP_READ, 6'd1, 6'd1);
    send_item(lca_pkg::OP_READ, 6'd31, 6'd62);
    send_item(lca_pkg::OP_READ, 6'd30, 6'd63);
  endtask

  task automatic test_unused_op();
    send_item(OP_UNUSED, 6'd63, 6'd63);
  endtask

  // 3x3 area: outside coordinates are flagged
  task automatic test_outside_area();
    set_area(2, 2);
    send_item(lca_pkg::OP_TOGGLE, 6'd3, 6'd0);
    send_item(lca_pkg::OP_READ, 6'd0, 6'd3);
    send_item(lca_pkg::OP_TOGGLE, 6'd63, 6'd63);
    send_item(lca_pkg::OP_STEP, 6'd0, 6'd0);
    send_item(lca_pkg::OP_READ, 6'd1, 6'd1);
  endtask

  // random items, mostly inside the area so patterns build up and evolve
  task automatic test_random_mix(int cols, int rows, int count);
    int k;
    logic [31:0] raw;
    set_area(cols, rows);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      raw = $urandom;
      if (k < 40)
        send_item(lca_pkg::OP_TOGGLE, lca_pkg::COORD_W'($urandom_range(0, cols)),
                  lca_pkg::COORD_W'($urandom_range(0, rows)));
      else if (k < 55)
        send_item(lca_pkg::OP_READ, lca_pkg::COORD_W'($urandom_range(0, cols)),
                  lca_pkg::COORD_W'($urandom_range(0, rows)));
      else if (k < 70)
        send_item(lca_pkg::OP_STEP, raw[11:6], raw[5:0]);
      else if (k < 85)
        send_item(raw[12] ? lca_pkg::OP_READ : lca_pkg::OP_TOGGLE, raw[11:6], raw[5:0]);
      else if (k < 92)
        send_item(OP_UNUSED, raw[11:6], raw[5:0]);
      else
        send_item(raw[13:12], raw[11:6], raw[5:0]);
    end
  endtask

  // result side stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result with the oldest pending answer
  always @(posedge clk) begin
    lca_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = pending_answers.pop_front();
        if (out_data.cell_value !== want.cell_value)
          report_mismatch($sformatf("cell_value %b, expected %b",
                                    out_data.cell_value, want.cell_value));
        if (out_data.out_of_area !== want.out_of_area)
          report_mismatch($sformatf("out_of_area %b, expected %b",
                                    out_data.out_of_area, want.out_of_area));
      end
    end
  end

  initial begin
    foreach (shadow_grid[r])
      shadow_grid[r] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_corners();
    test_edge_patterns();
    test_unused_op();
    test_outside_area();
    test_random_mix(63, 63, 20);
    test_random_mix(0, 0, 12);
    test_random_mix($urandom_range(0, 63), $urandom_range(0, 63), 30);
    test_random_mix(63, 4, 18);
    test_random_mix(5, 63, 18);
    // last stretch runs without idling on either side
    calm <= 1'b1;
    test_random_mix($urandom_range(8, 63), $urandom_range(8, 63), 22);
    wait_until_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
